### src/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the merge sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     dropped;
    } t_out_item;

endpackage

`default_nettype wire

### src/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### src/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Load, bottom-up merge passes between the two buffers, and emit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ctrl #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire mse_pkg::t_in_item         i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output mse_pkg::t_out_item             o_out_item,
    output logic                           o_we_a,
    output logic                           o_we_b,
    output logic [AW-1:0]                  o_waddr,
    output logic [mse_pkg::DATA_W-1:0]     o_wdata,
    output logic [AW-1:0]                  o_raddr_a,
    output logic [AW-1:0]                  o_raddr_b,
    input  wire logic [mse_pkg::DATA_W-1:0] i_a_rdata_a,
    input  wire logic [mse_pkg::DATA_W-1:0] i_a_rdata_b,
    input  wire logic [mse_pkg::DATA_W-1:0] i_b_rdata_a,
    input  wire logic [mse_pkg::DATA_W-1:0] i_b_rdata_b
);

    localparam int PW = CW + 1;
    localparam int SW = PW + 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

    typedef enum logic [1:0] {
        S_LOAD,
        S_PRIME,
        S_MERGE,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_n, n_n;
    logic [PW-1:0]     r_w, n_w;
    logic              r_src, n_src;
    logic [PW-1:0]     r_i, n_i;
    logic [PW-1:0]     r_j, n_j;
    logic [PW-1:0]     r_mid, n_mid;
    logic [PW-1:0]     r_hi, n_hi;
    logic [PW-1:0]     r_k, n_k;

    logic [mse_pkg::DATA_W-1:0] w_left, w_right;
    logic                       w_take_left;
    logic [PW-1:0]              w_nx;
    logic [SW-1:0]              w_nx_s, w_sum_mid, w_sum_hi;
    logic [PW-1:0]              w_k_inc;

    assign w_left   = r_src ? i_b_rdata_a : i_a_rdata_a;
    assign w_right  = r_src ? i_b_rdata_b : i_a_rdata_b;
    assign w_nx     = PW'(r_n);
    assign w_nx_s   = SW'(r_n);
    assign w_k_inc  = r_k + PW'(1);

    assign w_take_left = (r_i < r_mid) &&
                         ((r_j >= r_hi) || !($signed(w_right) < $signed(w_left)));

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_item.sorted_value = w_left;
    assign o_out_item.last_out     = ((r_i + PW'(1)) == w_nx);
    assign o_out_item.dropped      = r_ovf;

    assign o_raddr_a = n_i[AW-1:0];
    assign o_raddr_b = n_j[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_n       = r_n;
        n_w       = r_w;
        n_src     = r_src;
        n_i       = r_i;
        n_j       = r_j;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_k       = r_k;
        o_we_a    = 1'b0;
        o_we_b    = 1'b0;
        o_waddr   = r_k[AW-1:0];
        o_wdata   = w_take_left ? w_left : w_right;
        w_sum_mid = SW'(r_hi) + SW'(r_w);
        w_sum_hi  = SW'(r_hi) + (SW'(r_w) << 1);
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_fill < FULL) begin
                        o_we_a  = 1'b1;
                        o_waddr = r_fill[AW-1:0];
                        o_wdata = i_in_item.value;
                        n_fill  = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_item.last_in) begin
                        n_n     = n_fill;
                        n_fill  = '0;
                        n_w     = PW'(1);
                        n_src   = 1'b0;
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                n_i = '0;
                if (r_w < w_nx) begin
                    n_k     = '0;
                    n_mid   = (r_w < w_nx) ? r_w : w_nx;
                    n_j     = n_mid;
                    n_hi    = ((r_w << 1) < w_nx) ? (r_w << 1) : w_nx;
                    n_state = S_MERGE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MERGE: begin
                if (r_src) begin
                    o_we_a = 1'b1;
                end else begin
                    o_we_b = 1'b1;
                end
                n_k = w_k_inc;
                if (w_take_left) begin
                    n_i = r_i + PW'(1);
                end else begin
                    n_j = r_j + PW'(1);
                end
                if (w_k_inc == r_hi) begin
                    if (r_hi == w_nx) begin
                        n_src   = !r_src;
                        n_w     = r_w << 1;
                        n_state = S_PRIME;
                    end else begin
                        n_i   = r_hi;
                        n_mid = (w_sum_mid < w_nx_s) ? PW'(w_sum_mid) : w_nx;
                        n_j   = n_mid;
                        n_hi  = (w_sum_hi < w_nx_s) ? PW'(w_sum_hi) : w_nx;
                    end
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if ((r_i + PW'(1)) == w_nx) begin
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_i = r_i + PW'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_n     <= '0;
            r_w     <= '0;
            r_src   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_n     <= n_n;
            r_w     <= n_w;
            r_src   <= n_src;
            r_i     <= n_i;
            r_j     <= n_j;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
            r_k     <= n_k;
        end
    end

endmodule

`default_nettype wire

### src/merge_sort_engine_top.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_top
// Collects signed values into a set, sorts them ascending, emits them.
// ----------------------------------------------------------------------------
// Input items are taken one per cycle and written to buffer A; items past
// MAX_ITEMS are dropped and flag every result of that set. The item marked
// last starts the sort: ceil(log2(N)) bottom-up merge passes ping-pong
// between buffers A and B; each pass has a setup step, then writes all N
// merged values, one per cycle set by the single write port of the
// destination buffer, and one more setup step comes before the first
// result. Results then leave at one per cycle while the consumer is ready.
// No new item is taken until the last result of the current set has
// been delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_engine_top #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mse_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output mse_pkg::t_out_item     o_out_item
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic                       w_we_a, w_we_b;
    logic [AW-1:0]              w_waddr, w_raddr_a, w_raddr_b;
    logic [mse_pkg::DATA_W-1:0] w_wdata;
    logic [mse_pkg::DATA_W-1:0] w_a_rdata_a, w_a_rdata_b;
    logic [mse_pkg::DATA_W-1:0] w_b_rdata_a, w_b_rdata_b;

    mse_ram #(
        .WIDTH (mse_pkg::DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf_a (
        .i_clk     (i_clk),
        .i_we      (w_we_a),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_a_rdata_a),
        .o_rdata_b (w_a_rdata_b)
    );

    mse_ram #(
        .WIDTH (mse_pkg::DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf_b (
        .i_clk     (i_clk),
        .i_we      (w_we_b),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_b_rdata_a),
        .o_rdata_b (w_b_rdata_b)
    );

    mse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_we_a      (w_we_a),
        .o_we_b      (w_we_b),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr_a   (w_raddr_a),
        .o_raddr_b   (w_raddr_b),
        .i_a_rdata_a (w_a_rdata_a),
        .i_a_rdata_b (w_a_rdata_b),
        .i_b_rdata_a (w_b_rdata_a),
        .i_b_rdata_b (w_b_rdata_b)
    );

endmodule

`default_nettype wire
